>>> design/rgba_pixel_compositor_defines.svh
// ---------------------------------------------------------------------------
// RGBA pixel compositor assertion macros
// Shared property wrappers, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RGBA_PIXEL_COMPOSITOR_DEFINES_SVH
`define RGBA_PIXEL_COMPOSITOR_DEFINES_SVH

// same-cycle implication
`define RPC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rgba_pixel_compositor: assertion failed");

// next-cycle implication
`define RPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rgba_pixel_compositor: assertion failed");

`endif

>>> design/rpc_pkg.sv
// ---------------------------------------------------------------------------
// RGBA pixel compositor package
// Mode codes, register indices, reset values and pipeline control types.
// ---------------------------------------------------------------------------
package rpc_pkg;

   typedef enum logic [1:0] {
      MODE_SRC_ALPHA = 2'd0,
      MODE_THRESHOLD = 2'd1,
      MODE_EXPLICIT  = 2'd2,
      MODE_ADD       = 2'd3
   } blend_mode_type;

   typedef enum logic [1:0] {
      CSR_BLEND_MODE      = 2'd0,
      CSR_ALPHA_THRESHOLD = 2'd1,
      CSR_FIXED_ALPHA     = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

   localparam logic [7:0] THRESHOLD_RESET   = 8'd128;
   localparam logic [7:0] FIXED_ALPHA_RESET = 8'd255;
   localparam logic [7:0] CHAN_MAX          = 8'd255;
   localparam logic [15:0] KEEP_ROUND       = 16'd128;
   localparam logic [15:0] TAKE_ROUND       = 16'd127;

   // load strobes for the lane stages
   typedef struct packed {
      logic load2;
      logic load3;
   } rpc_adv_type;

endpackage

>>> design/rgba_pixel_compositor.sv
// ---------------------------------------------------------------------------
// RGBA pixel compositor
// Composites a source over a target RGBA8 pixel: alpha blend, threshold
// copy, explicit-alpha blend or saturating add, picked by blend_mode.
// ---------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | source and target pixel, 64 bits
//  rsp     | out | rsp_tvalid/tready   | composited pixel, 32 bits
//  csr     | in  | csr_valid/ready     | csr_index, csr_data
//
//  Four register stages; one pixel per clock sustained while rsp_tready stays high.
//  Latency is set by the multiply / divide-by-255 / sum pipeline.
//  Synchronous active-high reset empties the pipe and loads register defaults.
//  Stalls back up stage by stage; bubbles are squeezed out, nothing is lost.
// ---------------------------------------------------------------------------
`include "rgba_pixel_compositor_defines.svh"

module rgba_pixel_compositor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // source r,g,b,a then target r,g,b,a, 8 bits each, from bit 0 up
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result r,g,b,a, 8 bits each, from bit 0 up
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import rpc_pkg::*;

   blend_mode_type mode_ff, mode_in;
   logic [7:0]     thresh_ff, thresh_in;
   logic [7:0]     fixed_ff, fixed_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic load1, load2, load3, load4;
   logic free1, free2, free3, free4;
   rpc_adv_type adv;

   logic [3:0][7:0] src_in, tgt_in;
   logic [3:0][7:0] src_ff, tgt_ff;
   blend_mode_type  mode1_ff, mode2_ff, mode3_ff, mode4_ff;
   logic [7:0]      weight1_ff, weight1_in;
   logic            hit1_ff, hit1_in;
   logic [3:0][7:0] alt2_ff, alt2_in;
   logic [3:0][7:0] alt3_ff;
   logic [31:0]     out_ff, out_in;
   logic [2:0][7:0] mix;
   logic [8:0]      add_sum [3];
   csr_index_type   csr_sel;

   // configuration
   assign csr_ready = 1'b1;
   assign csr_sel   = csr_index_type'(csr_index);

   always_comb begin
      mode_in   = mode_ff;
      thresh_in = thresh_ff;
      fixed_in  = fixed_ff;
      if (csr_valid) begin
         case (csr_sel)
            CSR_BLEND_MODE:      mode_in   = blend_mode_type'(csr_data[1:0]);
            CSR_ALPHA_THRESHOLD: thresh_in = csr_data;
            CSR_FIXED_ALPHA:     fixed_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SRC_ALPHA;
         thresh_ff <= THRESHOLD_RESET;
         fixed_ff  <= FIXED_ALPHA_RESET;
      end else begin
         mode_ff   <= mode_in;
         thresh_ff <= thresh_in;
         fixed_ff  <= fixed_in;
      end
   end

   // pipeline flow control
   always_comb begin
      free4 = !v4_ff || rsp_tready;
      load4 = v3_ff && free4;
      free3 = !v3_ff || free4;
      load3 = v2_ff && free3;
      free2 = !v2_ff || free3;
      load2 = v1_ff && free2;
      free1 = !v1_ff || free2;
      load1 = req_tvalid && free1;
      v1_in = load1 || (v1_ff && !load2);
      v2_in = load2 || (v2_ff && !load3);
      v3_in = load3 || (v3_ff && !load4);
      v4_in = load4 || (v4_ff && !rsp_tready);
      adv.load2 = load2;
      adv.load3 = load3;
   end

   assign req_tready = free1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // stage 1: capture pixel, pick weight, threshold compare
   always_comb begin
      src_in     = req_tdata[31:0];
      tgt_in     = req_tdata[63:32];
      weight1_in = (mode_ff == MODE_EXPLICIT) ? fixed_ff : src_in[3];
      hit1_in    = src_in[3] >= thresh_ff;
   end

   // stage 2: threshold copy and saturating add results
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         add_sum[k] = {1'b0, tgt_ff[k]} + {1'b0, src_ff[k]};
      end
      case (mode1_ff)
         MODE_THRESHOLD: alt2_in = hit1_ff ? src_ff : tgt_ff;
         MODE_ADD: begin
            for (int k = 0; k < 3; k++) begin
               alt2_in[k] = add_sum[k][8] ? CHAN_MAX : add_sum[k][7:0];
            end
            alt2_in[3] = tgt_ff[3];
         end
         default: alt2_in = tgt_ff;
      endcase
   end

   // stage 4: result select
   always_comb begin
      case (mode3_ff)
         MODE_THRESHOLD, MODE_ADD: out_in = alt3_ff;
         default: out_in = {CHAN_MAX, mix[2], mix[1], mix[0]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         src_ff     <= src_in;
         tgt_ff     <= tgt_in;
         mode1_ff   <= mode_ff;
         weight1_ff <= weight1_in;
         hit1_ff    <= hit1_in;
      end
      if (load2) begin
         mode2_ff <= mode1_ff;
         alt2_ff  <= alt2_in;
      end
      if (load3) begin
         mode3_ff <= mode2_ff;
         alt3_ff  <= alt2_ff;
      end
      if (load4) begin
         mode4_ff <= mode3_ff;
         out_ff   <= out_in;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      rpc_mix_lane u_lane (
         .clock    (clock),
         .adv      (adv),
         .target_i (tgt_ff[k]),
         .source_i (src_ff[k]),
         .weight_i (weight1_ff),
         .mix_o    (mix[k])
      );
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = out_ff;

   `RPC_ASSERT_NOW(a_blend_alpha_opaque, rsp_tvalid && (mode4_ff == MODE_SRC_ALPHA || mode4_ff == MODE_EXPLICIT), rsp_tdata[31:24] == CHAN_MAX)
   `RPC_ASSERT_NEXT(a_drain_no_bubble, v3_ff && rsp_tready, rsp_tvalid)
   `RPC_ASSERT_NOW(a_backpressure_full, !req_tready, v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready)

endmodule

>>> design/rpc_mix_lane.sv
// ---------------------------------------------------------------------------
// RGBA pixel compositor blend lane
// One colour channel: rounded products, divide by 255 by add and shift, saturating sum.
// ---------------------------------------------------------------------------
module rpc_mix_lane (
   input  logic                 clock,
   input  rpc_pkg::rpc_adv_type adv,
   input  logic [7:0]           target_i,
   input  logic [7:0]           source_i,
   input  logic [7:0]           weight_i,
   output logic [7:0]           mix_o
);
   import rpc_pkg::*;

   logic [7:0]  inv_weight;
   logic [15:0] keep_p_ff, keep_p_in;
   logic [15:0] take_p_ff, take_p_in;
   logic [15:0] keep_s, take_s;
   logic [7:0]  keep_q_ff, keep_q_in;
   logic [7:0]  take_q_ff, take_q_in;
   logic [8:0]  sum;

   // stage 2: weighted products with rounding offsets (max 65153)
   always_comb begin
      inv_weight = CHAN_MAX - weight_i;
      keep_p_in  = {8'd0, inv_weight} * {8'd0, target_i} + KEEP_ROUND;
      take_p_in  = {8'd0, weight_i} * {8'd0, source_i} + TAKE_ROUND;
   end

   // stage 3: x / 255 == (x + 1 + (x >> 8)) >> 8 for x < 65535
   always_comb begin
      keep_s    = keep_p_ff + 16'd1 + {8'd0, keep_p_ff[15:8]};
      take_s    = take_p_ff + 16'd1 + {8'd0, take_p_ff[15:8]};
      keep_q_in = keep_s[15:8];
      take_q_in = take_s[15:8];
   end

   always_ff @(posedge clock) begin
      if (adv.load2) begin
         keep_p_ff <= keep_p_in;
         take_p_ff <= take_p_in;
      end
      if (adv.load3) begin
         keep_q_ff <= keep_q_in;
         take_q_ff <= take_q_in;
      end
   end

   always_comb begin
      sum   = {1'b0, keep_q_ff} + {1'b0, take_q_ff};
      mix_o = sum[8] ? CHAN_MAX : sum[7:0];
   end

endmodule

>>> sim/rgba_pixel_compositor_tb.sv
// ---------------------------------------------------------------------------
// RGBA pixel compositor testbench
// A table of directed transactions covers reset values, every blend mode, the
// threshold and weight extremes, ignored register writes and excess mode
// bits. It is followed by 16 phases of random pixels under changing register
// settings. Results are scored against a built-in compositing predictor, with
// random stalls on both streams, a long output hold-off and a full drain.
// ---------------------------------------------------------------------------
module rgba_pixel_compositor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rpc_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 16;
   localparam int PHASE_ITEMS  = 100;
   localparam int REPORT_LIMIT = 100;

   // red in the lowest byte
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgba_type;

   typedef struct {
      bit            is_csr;
      csr_index_type csr_sel;
      logic [7:0]    csr_val;
      rgba_type      src;
      rgba_type      tgt;
      bit            known;
      rgba_type      want;
   } plan_row_type;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata  = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index  = CSR_BLEND_MODE;
   logic [7:0]    csr_data   = '0;

   blend_mode_type mode_cfg      = MODE_SRC_ALPHA;
   logic [7:0]     threshold_cfg = THRESHOLD_RESET;
   logic [7:0]     weight_cfg    = FIXED_ALPHA_RESET;

   rgba_type     pending_pixels[$];
   plan_row_type plan_rows[$];
   int           mismatches     = 0;
   int           pixels_checked = 0;
   int           csr_writes     = 0;
   bit           quiet          = 1'b0;
   bit           hold_rsp       = 1'b0;

   rgba_pixel_compositor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d pixels outstanding", pending_pixels.size());
      $display("TB_ERROR");
      $finish;
   end

   function automatic rgba_type px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [7:0] a);
      return {a, b, g, r};
   endfunction

   function automatic logic [7:0] mix8(logic [7:0] t, logic [7:0] s, logic [7:0] w);
      int keep;
      int take;
      int sum;
      keep = ((255 - int'(w)) * int'(t) + 128) / 255;
      take = (int'(w) * int'(s) + 127) / 255;
      sum  = keep + take;
      return (sum > 255) ? CHAN_MAX : 8'(sum);
   endfunction

   function automatic logic [7:0] add8(logic [7:0] t, logic [7:0] s);
      logic [8:0] sum;
      sum = {1'b0, t} + {1'b0, s};
      return sum[8] ? CHAN_MAX : sum[7:0];
   endfunction

   function automatic rgba_type composite(rgba_type s, rgba_type t);
      rgba_type   res;
      logic [7:0] w;
      case (mode_cfg)
         MODE_THRESHOLD: begin
            res = (s.alpha >= threshold_cfg) ? s : t;
         end
         MODE_ADD: begin
            res.red   = add8(t.red, s.red);
            res.green = add8(t.green, s.green);
            res.blue  = add8(t.blue, s.blue);
            res.alpha = t.alpha;
         end
         default: begin
            w = (mode_cfg == MODE_EXPLICIT) ? weight_cfg : s.alpha;
            res.red   = mix8(t.red, s.red, w);
            res.green = mix8(t.green, s.green, w);
            res.blue  = mix8(t.blue, s.blue, w);
            res.alpha = CHAN_MAX;
         end
      endcase
      return res;
   endfunction

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void plan_csr(csr_index_type sel, logic [7:0] val);
      plan_row_type row;
      row = '{is_csr: 1'b1, csr_sel: sel, csr_val: val, default: '0};
      plan_rows.push_back(row);
   endfunction

   function automatic void plan_pixel(rgba_type src, rgba_type tgt, bit known = 1'b0,
                                      rgba_type want = '0);
      plan_row_type row;
      row = '{is_csr: 1'b0, csr_sel: CSR_BLEND_MODE, csr_val: 8'h00, src: src,
              tgt: tgt, known: known, want: want};
      plan_rows.push_back(row);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatches < REPORT_LIMIT)
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task automatic wait_drained();
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // csr_valid is left high; the next pixel transaction lowers it
   task automatic write_reg(csr_index_type sel, logic [7:0] val);
      req_tvalid <= 1'b0;
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      case (sel)
         CSR_BLEND_MODE:      mode_cfg = blend_mode_type'(val[1:0]);
         CSR_ALPHA_THRESHOLD: threshold_cfg = val;
         CSR_FIXED_ALPHA:     weight_cfg = val;
         default: ;
      endcase
   endtask

   task automatic send_pixel(rgba_type src, rgba_type tgt, bit known, rgba_type want);
      if (!quiet) begin
         while ($urandom_range(99) < 11) begin
            csr_valid  <= 1'b0;
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      csr_valid  <= 1'b0;
      req_tvalid <= 1'b1;
      req_tdata  <= {tgt, src};
      do @(posedge clock); while (!req_tready);
      pending_pixels.push_back(known ? want : composite(src, tgt));
   endtask

   // output side: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 11);
         end
      end
   end

   always @(posedge clock) begin
      rgba_type got;
      rgba_type want;
      string    chan_name[4];
      chan_name = '{"red", "green", "blue", "alpha"};
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         pixels_checked++;
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected pixel", got, 0);
         end else begin
            want = pending_pixels.pop_front();
            for (int k = 0; k < 4; k++)
               if (got[8*k +: 8] !== want[8*k +: 8])
                  report_mismatch(chan_name[k], got[8*k +: 8], want[8*k +: 8]);
         end
      end
   end

   initial begin
      blend_mode_type mode_order[4];
      rgba_type       src;
      rgba_type       tgt;
      mode_order = '{MODE_SRC_ALPHA, MODE_THRESHOLD, MODE_EXPLICIT, MODE_ADD};

      // reset register values: source alpha blend
      plan_pixel(px(10, 20, 30, 255), px(200, 100, 50, 7), 1, px(10, 20, 30, 255));
      plan_pixel(px(10, 20, 30, 0), px(200, 100, 50, 7), 1, px(200, 100, 50, 255));
      plan_pixel(px(255, 255, 255, 128), px(255, 255, 255, 0), 1,
                 px(255, 255, 255, 255));
      plan_pixel(px(0, 0, 0, 0), px(0, 0, 0, 0), 1, px(0, 0, 0, 255));
      plan_pixel(px(1, 2, 3, 128), px(254, 253, 252, 9));
      plan_pixel(px(255, 0, 255, 1), px(0, 255, 0, 254));
      // threshold copy, zero threshold always copies
      plan_csr(CSR_ALPHA_THRESHOLD, 8'h00);
      plan_csr(CSR_BLEND_MODE, 8'(MODE_THRESHOLD));
      plan_pixel(px(11, 22, 33, 0), px(44, 55, 66, 77), 1, px(11, 22, 33, 0));
      plan_csr(CSR_ALPHA_THRESHOLD, 8'hFF);
      plan_pixel(px(11, 22, 33, 254), px(44, 55, 66, 77), 1, px(44, 55, 66, 77));
      plan_pixel(px(11, 22, 33, 255), px(44, 55, 66, 77), 1, px(11, 22, 33, 255));
      plan_csr(CSR_ALPHA_THRESHOLD, THRESHOLD_RESET);
      plan_pixel(px(11, 22, 33, 127), px(44, 55, 66, 77), 1, px(44, 55, 66, 77));
      plan_pixel(px(11, 22, 33, 128), px(44, 55, 66, 77), 1, px(11, 22, 33, 128));
      // explicit weight; upper mode bits must be dropped
      plan_csr(CSR_FIXED_ALPHA, 8'h00);
      plan_csr(CSR_BLEND_MODE, 8'hFC | 8'(MODE_EXPLICIT));
      plan_pixel(px(9, 8, 7, 255), px(90, 80, 70, 1), 1, px(90, 80, 70, 255));
      plan_csr(CSR_FIXED_ALPHA, 8'hFF);
      plan_pixel(px(9, 8, 7, 0), px(90, 80, 70, 1), 1, px(9, 8, 7, 255));
      plan_csr(CSR_FIXED_ALPHA, 8'd77);
      plan_pixel(px(9, 8, 7, 3), px(90, 80, 70, 1));
      plan_pixel(px(255, 255, 255, 0), px(0, 0, 0, 255));
      // saturating add; a write to the spare index changes nothing
      plan_csr(CSR_BLEND_MODE, 8'(MODE_ADD));
      plan_pixel(px(200, 1, 0, 9), px(100, 254, 0, 33), 1, px(255, 255, 0, 33));
      plan_pixel(px(255, 255, 255, 255), px(255, 255, 255, 255), 1,
                 px(255, 255, 255, 255));
      plan_pixel(px(0, 0, 0, 0), px(0, 0, 0, 0), 1, px(0, 0, 0, 0));
      plan_csr(CSR_UNUSED, 8'h00);
      plan_pixel(px(1, 2, 3, 4), px(5, 6, 7, 8), 1, px(6, 8, 10, 8));
      plan_pixel(px(128, 127, 129, 200), px(127, 128, 126, 100));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_rows[i]) begin
         if (plan_rows[i].is_csr)
            write_reg(plan_rows[i].csr_sel, plan_rows[i].csr_val);
         else
            send_pixel(plan_rows[i].src, plan_rows[i].tgt, plan_rows[i].known,
                       plan_rows[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_BLEND_MODE, 8'(mode_order[p % 4]));
         write_reg(CSR_ALPHA_THRESHOLD, (p < 4) ? 8'hFF : (p < 8) ? 8'h00 : 8'($urandom));
         write_reg(CSR_FIXED_ALPHA, (p < 4) ? 8'h00 : (p < 8) ? 8'hFF : 8'($urandom));
         if (p % 5 == 4)
            write_reg(CSR_UNUSED, 8'($urandom));
         quiet    = (p == 5);
         hold_rsp = (p == 7);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 9 && n == PHASE_ITEMS / 2) begin
               req_tvalid <= 1'b0;
               wait_drained();
            end
            src = px(rand_chan(), rand_chan(), rand_chan(), rand_chan());
            tgt = px(rand_chan(), rand_chan(), rand_chan(), rand_chan());
            // aim at the threshold edge
            if (mode_cfg == MODE_THRESHOLD && $urandom_range(2) == 0)
               src.alpha = threshold_cfg + 8'($urandom_range(2)) - 8'd1;
            send_pixel(src, tgt, 1'b0, '0);
         end
      end
      quiet = 1'b0;

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0)
         report_mismatch("pixels never returned", pending_pixels.size(), 0);

      $display("checked %0d composited pixels across %0d register writes", pixels_checked,
               csr_writes);
      $display("all four modes, threshold and weight extremes, stalls and a long hold-off");
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
